// ===== design/cha_pkg.sv =====
// shared types and constants for the chacha20 stream cipher
// no dependencies; imported by every module of the block
package cha_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    // one block travelling along the round chain
    typedef struct packed {
        logic   valid;
        state_t state;
    } blk_t;

    localparam word_t SIGMA_0 = 32'h61707865;
    localparam word_t SIGMA_1 = 32'h3320646e;
    localparam word_t SIGMA_2 = 32'h79622d32;
    localparam word_t SIGMA_3 = 32'h6b206574;

    localparam int BLOCK_BYTES = 64;

    // configuration register indexes
    localparam logic [3:0] REG_KEY_0     = 4'd0;
    localparam logic [3:0] REG_KEY_1     = 4'd1;
    localparam logic [3:0] REG_KEY_2     = 4'd2;
    localparam logic [3:0] REG_KEY_3     = 4'd3;
    localparam logic [3:0] REG_NONCE_LO  = 4'd4;
    localparam logic [3:0] REG_NONCE_HI  = 4'd5;
    localparam logic [3:0] REG_INIT_CTR  = 4'd6;
    localparam logic [3:0] REG_MODE      = 4'd7;

    localparam logic MODE_XOR = 1'b0;

endpackage

// ===== design/cha_round_cell.sv =====
// one chacha round cell: four quarter rounds on the state, registered
// depends on cha_pkg; DIAG selects column or diagonal grouping
module cha_round_cell #(
    parameter int DIAG = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cha_pkg::blk_t blk_in,
    output cha_pkg::blk_t blk_out
);
    import cha_pkg::*;

    typedef word_t [3:0] quad_t;

    function automatic word_t rotl(input word_t x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // quarter round on a, b, c, d
    function automatic quad_t quarter(input quad_t q);
        word_t a, b, c, d;
        a = q[0]; b = q[1]; c = q[2]; d = q[3];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter = {d, c, b, a};
    endfunction

    state_t round_s;
    blk_t   blk_reg;

    // four independent quarter rounds
    always_comb begin
        quad_t q;
        int ia, ib, ic, id;
        round_s = blk_in.state;
        for (int k = 0; k < 4; k++) begin
            ia = k;
            ib = 4 + ((k + DIAG) % 4);
            ic = 8 + ((k + 2 * DIAG) % 4);
            id = 12 + ((k + 3 * DIAG) % 4);
            q = quarter({blk_in.state[id], blk_in.state[ic],
                         blk_in.state[ib], blk_in.state[ia]});
            round_s[ia] = q[0];
            round_s[ib] = q[1];
            round_s[ic] = q[2];
            round_s[id] = q[3];
        end
    end

    // hand the block to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg.valid <= 1'b0;
        end else begin
            blk_reg.valid <= blk_in.valid;
        end
        blk_reg.state <= round_s;
    end

    assign blk_out = blk_reg;

endmodule

// ===== design/cha_core.sv =====
// keystream core: chain of round cells and the final feed-forward add
// depends on cha_pkg and cha_round_cell
module cha_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            launch,
    input  cha_pkg::state_t init_state,
    output cha_pkg::blk_t   ks_out
);
    import cha_pkg::*;

    localparam int CELLS = 2 * DOUBLE_ROUNDS;

    blk_t   chain [CELLS + 1];
    state_t init_reg;
    blk_t   ks_reg;

    assign chain[0].valid = launch;
    assign chain[0].state = init_state;

    // row of round cells, column and diagonal in turn
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        cha_round_cell #(.DIAG(g % 2)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .blk_in  (chain[g]),
            .blk_out (chain[g + 1])
        );
    end

    // input state kept for the feed-forward
    always_ff @(posedge aclk) begin
        if (launch) begin
            init_reg <= init_state;
        end
    end

    // final add of the input state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ks_reg.valid <= 1'b0;
        end else begin
            ks_reg.valid <= chain[CELLS].valid;
        end
        for (int i = 0; i < 16; i++) begin
            ks_reg.state[i] <= chain[CELLS].state[i] + init_reg[i];
        end
    end

    assign ks_out = ks_reg;

endmodule

// ===== design/chacha20_stream_cipher.sv =====
// chacha20 stream cipher top level: configuration, byte stream control
// depends on cha_pkg and cha_core
//
//  channel  | direction | contents
//  s_       | in        | tdata: data_in[63:0], byte_count[67:64]; tuser: start_req
//  m_       | out       | tdata: data_out[63:0], valid_bytes[67:64]
//  cfg_     | in        | cfg_index register number, cfg_data write value
//
// an item whose bytes lie in the held block is served from that block; one that needs a
// new block waits for the round chain and the final add before it completes.
// reset (aresetn low, synchronous) empties all stages and marks a block needed.
// the output register frees the input side while a result waits for m_tready.
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_in[63:0], byte_count[67:64], zero pad
    input  logic        s_tuser,   // start_req
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // data_out[63:0], valid_bytes[67:64], zero pad
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import cha_pkg::*;

    // configuration
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] init_ctr_reg;
    logic        mode_reg;

    // stream state
    logic [6:0]   off_reg;
    logic [31:0]  ctr_reg;
    logic         busy_reg;
    logic [511:0] ks_reg;

    // work stage
    logic         w_valid_reg;
    logic [63:0]  w_data_reg;
    logic [3:0]   w_cnt_reg;
    logic [3:0]   w_idx_reg;
    logic [63:0]  w_res_reg;

    // output stage
    logic         o_valid_reg;
    logic [63:0]  o_data_reg;
    logic [3:0]   o_cnt_reg;

    logic [6:0]   avail;
    logic [3:0]   rem;
    logic [3:0]   take;
    logic [3:0]   idx_now;
    logic [63:0]  res_now;
    logic         done_now;
    logic         out_free;
    logic         w_fin;
    logic         s_acc;
    logic         launch;
    logic [3:0]   in_cnt;
    state_t       init_state;
    blk_t         ks_out;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                key_reg[i] <= '0;
            end
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            init_ctr_reg <= '0;
            mode_reg     <= MODE_XOR;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY_0:    key_reg[0]   <= cfg_data;
                REG_KEY_1:    key_reg[1]   <= cfg_data;
                REG_KEY_2:    key_reg[2]   <= cfg_data;
                REG_KEY_3:    key_reg[3]   <= cfg_data;
                REG_NONCE_LO: nonce_lo_reg <= cfg_data;
                REG_NONCE_HI: nonce_hi_reg <= cfg_data[31:0];
                REG_INIT_CTR: init_ctr_reg <= cfg_data[31:0];
                REG_MODE:     mode_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // bytes taken from the held block this cycle
    assign avail   = 7'(BLOCK_BYTES) - off_reg;
    assign rem     = w_cnt_reg - w_idx_reg;
    assign take    = ({3'b000, rem} < avail) ? rem : avail[3:0];
    assign idx_now = w_idx_reg + take;

    always_comb begin
        logic [6:0] p;
        logic [7:0] ks_b;
        logic [7:0] d_b;
        res_now = w_res_reg;
        for (int j = 0; j < 8; j++) begin
            p    = off_reg + 7'(j) - {3'b000, w_idx_reg};
            ks_b = ks_reg[{p[5:0], 3'b000} +: 8];
            d_b  = w_data_reg[j*8 +: 8];
            if (4'(j) >= w_idx_reg && 4'(j) < idx_now) begin
                res_now[j*8 +: 8] = (mode_reg == MODE_XOR) ? (d_b ^ ks_b) : ks_b;
            end
        end
    end

    // handshake and sequencing
    assign done_now = w_valid_reg && (idx_now == w_cnt_reg);
    assign out_free = !o_valid_reg || m_tready;
    assign w_fin    = done_now && out_free;
    assign s_tready = !w_valid_reg || w_fin;
    assign s_acc    = s_tvalid && s_tready;
    assign launch   = w_valid_reg && !done_now && (off_reg == 7'(BLOCK_BYTES)) && !busy_reg;
    assign in_cnt   = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];

    // block input state
    always_comb begin
        init_state[0] = SIGMA_0;
        init_state[1] = SIGMA_1;
        init_state[2] = SIGMA_2;
        init_state[3] = SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            init_state[4 + 2*i]     = key_reg[i][31:0];
            init_state[4 + 2*i + 1] = key_reg[i][63:32];
        end
        init_state[12] = ctr_reg;
        init_state[13] = nonce_lo_reg[31:0];
        init_state[14] = nonce_lo_reg[63:32];
        init_state[15] = nonce_hi_reg;
    end

    cha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .launch     (launch),
        .init_state (init_state),
        .ks_out     (ks_out)
    );

    // keystream position, counter and block request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg  <= 7'(BLOCK_BYTES);
            ctr_reg  <= '0;
            busy_reg <= 1'b0;
            ks_reg   <= '0;
        end else begin
            if (w_valid_reg) begin
                off_reg <= off_reg + {3'b000, take};
            end
            if (launch) begin
                busy_reg <= 1'b1;
                ctr_reg  <= ctr_reg + 32'd1;
            end
            if (ks_out.valid) begin
                busy_reg <= 1'b0;
                off_reg  <= '0;
                ks_reg   <= ks_out.state;
            end
            if (s_acc && s_tuser) begin
                off_reg <= 7'(BLOCK_BYTES);
                ctr_reg <= init_ctr_reg;
            end
        end
    end

    // work stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (s_acc) begin
            w_valid_reg <= 1'b1;
        end else if (w_fin) begin
            w_valid_reg <= 1'b0;
        end
        if (s_acc) begin
            w_data_reg <= s_tdata[63:0];
            w_cnt_reg  <= in_cnt;
            w_idx_reg  <= '0;
            w_res_reg  <= '0;
        end else if (w_valid_reg) begin
            w_idx_reg  <= idx_now;
            w_res_reg  <= res_now;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (w_fin) begin
            o_valid_reg <= 1'b1;
        end else if (m_tready) begin
            o_valid_reg <= 1'b0;
        end
        if (w_fin) begin
            o_data_reg <= res_now;
            o_cnt_reg  <= w_cnt_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {4'b0000, o_cnt_reg, o_data_reg};

endmodule
